FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i and switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define DRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define DRS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// Record splitter package
// Shared constants, codes and types of the delimited record splitter.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int unsigned SepMaxBytesDef = 8;
  // The separator register holds at most this many bytes.
  localparam int unsigned SepCap  = 8;
  localparam int unsigned SepW    = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW    = 4;

  localparam logic [SepW-1:0] SepBytesRst = 64'd10;
  localparam logic [LenW-1:0] SepLenRst   = 4'd1;
  localparam logic [CntW-1:0] MaxResults  = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEP_BYTES = 2'd0,
    REG_SEP_LEN   = 2'd1,
    REG_INCL_SEP  = 2'd2,
    REG_BIN_MODE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_FEED
  } rb_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_CONT1,
    U_CONT2,
    U_CONT3,
    U_AFTER_E0,
    U_AFTER_ED,
    U_AFTER_F0,
    U_AFTER_F4
  } utf8_e;

  typedef struct packed {
    logic step;
    logic drop;
  } cell_ctrl_t;

  // Results of one item: nsep separator-prefix bytes, then optionally the
  // item's own byte, then optionally a record end.
  typedef struct packed {
    logic [CntW-1:0] nsep;
    logic            with_byte;
    logic            with_end;
    logic [7:0]      data;
  } job_t;

endpackage

FILE: rtl/drs_cell.sv
// ----------------------------------------------------------------------------
// Match cell
// Tracks whether a partial separator match of one fixed length is live.
// ----------------------------------------------------------------------------
module drs_cell
  import drs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prev_i,
  input  logic [7:0] sep_byte_i,
  input  logic [7:0] data_i,
  input  logic       enable_i,
  input  logic       keep_i,
  output logic       hit_o,
  output logic       act_o
);

  logic act_q, act_d;

  // A match one byte shorter was live and this byte extends it.
  assign hit_o = prev_i && enable_i && (data_i == sep_byte_i);
  assign act_d = ctrl_i.drop ? 1'b0 : (hit_o && keep_i);
  assign act_o = act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.step) begin
      act_q <= act_d;
    end
  end

endmodule

FILE: rtl/drs_utf8.sv
// ----------------------------------------------------------------------------
// UTF-8 checker
// Strict UTF-8 decoder state and error flag of the record being emitted.
// ----------------------------------------------------------------------------
module drs_utf8
  import drs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       feed_i,
  input  logic [7:0] byte_i,
  input  logic       close_i,
  output logic       bad_o
);

  utf8_e st_q, st_d;
  logic  bad_q, bad_d;
  logic  ok;
  utf8_e nxt;

  always_comb begin
    st_d  = st_q;
    bad_d = bad_q;
    ok    = 1'b1;
    nxt   = U_IDLE;
    if (close_i) begin
      st_d  = U_IDLE;
      bad_d = 1'b0;
    end else if (feed_i) begin
      if (st_q == U_IDLE) begin
        if (byte_i < 8'h80) begin
          nxt = U_IDLE;
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
          nxt = U_CONT1;
        end else if (byte_i == 8'hE0) begin
          nxt = U_AFTER_E0;
        end else if (byte_i == 8'hED) begin
          nxt = U_AFTER_ED;
        end else if (byte_i >= 8'hE1 && byte_i <= 8'hEF) begin
          nxt = U_CONT2;
        end else if (byte_i == 8'hF0) begin
          nxt = U_AFTER_F0;
        end else if (byte_i >= 8'hF1 && byte_i <= 8'hF3) begin
          nxt = U_CONT3;
        end else if (byte_i == 8'hF4) begin
          nxt = U_AFTER_F4;
        end else begin
          ok = 1'b0;
        end
      end else begin
        case (st_q)
          U_AFTER_E0: begin
            ok  = byte_i >= 8'hA0 && byte_i <= 8'hBF;
            nxt = U_CONT1;
          end
          U_AFTER_ED: begin
            ok  = byte_i >= 8'h80 && byte_i <= 8'h9F;
            nxt = U_CONT1;
          end
          U_AFTER_F0: begin
            ok  = byte_i >= 8'h90 && byte_i <= 8'hBF;
            nxt = U_CONT2;
          end
          U_AFTER_F4: begin
            ok  = byte_i >= 8'h80 && byte_i <= 8'h8F;
            nxt = U_CONT2;
          end
          U_CONT3: begin
            ok  = byte_i[7:6] == 2'b10;
            nxt = U_CONT2;
          end
          U_CONT2: begin
            ok  = byte_i[7:6] == 2'b10;
            nxt = U_CONT1;
          end
          U_CONT1: begin
            ok  = byte_i[7:6] == 2'b10;
            nxt = U_IDLE;
          end
          default: begin
            ok = 1'b0;
          end
        endcase
      end
      // An error marks the record and restarts the decoder.
      if (ok) begin
        st_d = nxt;
      end else begin
        st_d  = U_IDLE;
        bad_d = 1'b1;
      end
    end
  end

  // A sequence still open at the record end counts as an error too.
  assign bad_o = bad_q || (st_q != U_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= U_IDLE;
      bad_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      bad_q <= bad_d;
    end
  end

endmodule

FILE: rtl/drs_emit.sv
// ----------------------------------------------------------------------------
// Result emitter
// Walks one item's results out via an output register, a beat per unstalled cycle.
// ----------------------------------------------------------------------------
module drs_emit
  import drs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  job_t            job_i,
  output logic            free_o,
  input  logic [SepW-1:0] sep_i,
  input  logic            bin_mode_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  `include "assert_macros.svh"

  job_t            job_q;
  logic            job_valid_q;
  logic [CntW-1:0] pos_q;
  logic [CntW-1:0] total;
  logic            last_now;
  logic            produce;
  logic [7:0]      sep_b [SepCap];

  kind_e      cur_kind;
  logic [7:0] cur_byte;
  logic       bad;

  logic       ov_q;
  kind_e      okind_q;
  logic [7:0] obyte_q;
  logic       olast_q;

  always_comb begin
    for (int i = 0; i < SepCap; i++) begin
      sep_b[i] = sep_i[8*i +: 8];
    end
  end

  assign total = job_q.nsep + CntW'(job_q.with_byte) + CntW'(job_q.with_end);
  assign last_now = (pos_q == total - CntW'(1));
  assign produce  = job_valid_q && (!ov_q || out_ready_i);
  assign free_o   = !job_valid_q || (produce && last_now);

  always_comb begin
    if (pos_q < job_q.nsep) begin
      cur_kind = KIND_BYTE;
      cur_byte = sep_b[pos_q[2:0]];
    end else if (job_q.with_byte && pos_q == job_q.nsep) begin
      cur_kind = KIND_BYTE;
      cur_byte = job_q.data;
    end else begin
      cur_kind = (bin_mode_i || !bad) ? KIND_GOOD : KIND_DROP;
      cur_byte = 8'd0;
    end
  end

  drs_utf8 u_utf8 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feed_i  (produce && cur_kind == KIND_BYTE),
    .byte_i  (cur_byte),
    .close_i (produce && cur_kind != KIND_BYTE),
    .bad_o   (bad)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      pos_q       <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (push_i) begin
        job_valid_q <= 1'b1;
        pos_q       <= '0;
      end else if (produce) begin
        if (last_now) begin
          job_valid_q <= 1'b0;
        end else begin
          pos_q <= pos_q + CntW'(1);
        end
      end
      if (produce) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q <= job_i;
    end
    if (produce) begin
      okind_q <= cur_kind;
      obyte_q <= cur_byte;
      olast_q <= last_now;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = okind_q;
  assign out_byte_o  = obyte_q;
  assign last_o      = olast_q;

  `DRS_ASSERT(a_job_size, job_valid_q |-> (total != '0 && total <= MaxResults), "bad job size")
  `DRS_ASSERT(a_pos_in_job, job_valid_q |-> (pos_q < total), "position beyond job")
  `DRS_ASSERT(a_end_is_last, (out_valid_o && okind_q != KIND_BYTE) |-> last_o, "end not last")

endmodule

FILE: rtl/delimited_record_splitter.sv
// ----------------------------------------------------------------------------
// Delimited record splitter
// Cuts a byte stream into records at a configurable separator of up to eight
// bytes, holding back possible separator bytes, with strict UTF-8 checking.
//
//   channel  signals                                        direction
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i              write only
//   in       in_valid_i/in_ready_o, data_byte_i, end_of_stream_i
//   out      out_valid_o/out_ready_i, kind_o, out_byte_o, last_o
//
// An item is taken every cycle while each causes at most one result and the
// output does not stall; an item with more results (up to 9) holds the input
// until the emitter, which hands out one beat per unstalled cycle behind an
// output register, produces its last result. After a configuration write
// the input stalls while the row of match cells replays the held bytes.
// Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module delimited_record_splitter
  import drs_pkg::*;
#(
  parameter int unsigned SEP_MAX_BYTES = SepMaxBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SepW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_stream_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  `include "assert_macros.svh"

  localparam int unsigned     SepLim  = (SEP_MAX_BYTES < SepCap) ? SEP_MAX_BYTES : SepCap;
  localparam logic [LenW-1:0] SepLimL = LenW'(SepLim);

  logic [SepW-1:0] sep_q;
  logic [LenW-1:0] len_q;
  logic            incl_q;
  logic            bin_q;
  logic [LenW-1:0] eff_len;
  logic [7:0]      sep_b [SepCap];

  cell_ctrl_t      ctrl;
  logic [7:0]      feed_byte;
  logic [SepLim-1:0] hit, act;
  logic [SepLim:0]   chain;
  logic [LenW-1:0] depth;
  logic [LenW-1:0] k;
  logic            full;

  rb_state_e       state_q, state_d;
  logic [LenW-1:0] tgt_q, tgt_d, tgt_eff;
  logic [LenW-1:0] cnt_q, cnt_d;

  logic            in_fire;
  logic            emit_free;
  job_t            job;
  logic            has_out;
  logic            nonempty_q, nonempty_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q  <= SepBytesRst;
      len_q  <= SepLenRst;
      incl_q <= 1'b0;
      bin_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SEP_BYTES: sep_q  <= cfg_data_i;
        REG_SEP_LEN:   len_q  <= cfg_data_i[LenW-1:0];
        REG_INCL_SEP:  incl_q <= cfg_data_i[0];
        REG_BIN_MODE:  bin_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      eff_len = LenW'(1);
    end else if (len_q > SepLimL) begin
      eff_len = SepLimL;
    end else begin
      eff_len = len_q;
    end
  end

  always_comb begin
    for (int i = 0; i < SepCap; i++) begin
      sep_b[i] = sep_q[8*i +: 8];
    end
  end

  // Cell c tracks a live partial match of length c + 1.
  assign chain = {act, 1'b1};

  for (genvar c = 0; c < SepLim; c++) begin : g_cell
    localparam logic [LenW-1:0] Len = LenW'(c + 1);
    drs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_i     (chain[c]),
      .sep_byte_i (sep_q[8*c +: 8]),
      .data_i     (feed_byte),
      .enable_i   (Len <= eff_len),
      .keep_i     (Len < eff_len),
      .hit_o      (hit[c]),
      .act_o      (act[c])
    );
  end

  // The longest live match is the number of held bytes; the longest hit is
  // the number still held after this byte, unless it is a full separator match.
  always_comb begin
    depth = '0;
    k     = '0;
    for (int c = 0; c < SepLim; c++) begin
      if (act[c]) depth = LenW'(c + 1);
      if (hit[c]) k = LenW'(c + 1);
    end
  end

  assign full    = (k == eff_len);
  assign tgt_eff = (tgt_q < eff_len) ? tgt_q : eff_len - LenW'(1);

  assign in_ready_o = (state_q == ST_RUN) && !cfg_we_i && emit_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // After a configuration write the held bytes are replayed from the new
  // separator through the cells to rebuild the set of live matches.
  // The held count as left by the last accepted beat lives in tgt_q, so a
  // later write still sees it uncut; only the replay applies the limit.
  always_comb begin
    state_d   = state_q;
    tgt_d     = tgt_q;
    cnt_d     = cnt_q;
    ctrl      = '0;
    feed_byte = data_byte_i;
    case (state_q)
      ST_RUN: begin
        if (cfg_we_i) begin
          state_d = ST_LOAD;
        end else if (in_fire) begin
          ctrl.step = 1'b1;
          ctrl.drop = end_of_stream_i || full;
          tgt_d     = ctrl.drop ? '0 : k;
        end
      end
      ST_LOAD: begin
        if (!cfg_we_i) begin
          ctrl.step = 1'b1;
          ctrl.drop = 1'b1;
          cnt_d     = '0;
          state_d   = ST_FEED;
        end
      end
      ST_FEED: begin
        if (cfg_we_i) begin
          state_d = ST_LOAD;
        end else if (cnt_q == tgt_eff) begin
          state_d = ST_RUN;
        end else begin
          ctrl.step = 1'b1;
          feed_byte = sep_b[cnt_q[2:0]];
          cnt_d     = cnt_q + LenW'(1);
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      tgt_q      <= '0;
      cnt_q      <= '0;
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      tgt_q      <= tgt_d;
      cnt_q      <= cnt_d;
      nonempty_q <= nonempty_d;
    end
  end

  // Results of the accepted item.
  always_comb begin
    job.data      = data_byte_i;
    job.nsep      = '0;
    job.with_byte = 1'b0;
    job.with_end  = 1'b0;
    if (end_of_stream_i) begin
      job.nsep     = depth;
      job.with_end = nonempty_q || (depth != '0);
    end else if (full) begin
      job.nsep     = incl_q ? eff_len : '0;
      job.with_end = 1'b1;
    end else if (k == '0) begin
      job.nsep      = depth;
      job.with_byte = 1'b1;
    end else begin
      job.nsep = depth + LenW'(1) - k;
    end
  end

  assign has_out = (job.nsep != '0) || job.with_byte || job.with_end;

  always_comb begin
    nonempty_d = nonempty_q;
    if (in_fire) begin
      if (job.with_end) begin
        nonempty_d = 1'b0;
      end else if (has_out) begin
        nonempty_d = 1'b1;
      end
    end
  end

  drs_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire && has_out),
    .job_i       (job),
    .free_o      (emit_free),
    .sep_i       (sep_q),
    .bin_mode_i  (bin_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  `DRS_ASSERT(a_depth_below_len, (state_q == ST_RUN) |-> (depth < eff_len), "held too many")
  `DRS_ASSERT(a_match_clears, (in_fire && !end_of_stream_i && full) |=> (depth == '0), "match kept")
  `DRS_ASSERT(a_rebuild_depth, (state_q == ST_FEED && cnt_q == tgt_eff) |-> (depth == tgt_eff), "rebuild off")

endmodule

FILE: tb/delimited_record_splitter_test.sv
// ----------------------------------------------------------------------------
// Delimited record splitter testbench
// Sends byte streams through the splitter under several separator settings.
// Each beat is checked against an in-bench prediction of the records, held
// bytes and UTF-8 verdicts. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module delimited_record_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drs_pkg::*;

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned SettleCycles  = 16;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SepLimit      = (SepMaxBytesDef < SepCap) ? SepMaxBytesDef : SepCap;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_PATTERN,
    RDY_COIN
  } ready_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [SepW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               end_of_stream_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [7:0]         out_byte_o;
  logic               last_o;

  // Predicted configuration and splitter state.
  logic [SepW-1:0] sep_word = SepBytesRst;
  logic [LenW-1:0] sep_len  = SepLenRst;
  logic            incl_sep = 1'b0;
  logic            bin_mode = 1'b0;
  logic [3:0]      held_cnt = '0;
  logic            rec_open = 1'b0;
  logic            rec_bad  = 1'b0;
  utf8_e           u8_state = U_IDLE;

  beat_t       expected_beats[$];
  beat_t       step_beats[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          steady_input = 1'b0;

  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned mode_left  = 0;
  logic [7:0]  ready_mask = 8'hFF;

  delimited_record_splitter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned eff_sep_len();
    int unsigned lim;
    lim = (SepLimit < 1) ? 1 : SepLimit;
    if (sep_len == 0) return 1;
    if (sep_len > lim) return lim;
    return sep_len;
  endfunction

  function automatic logic [7:0] sep_byte(input int unsigned i);
    return sep_word[(i % 8) * 8 +: 8];
  endfunction

  function automatic void utf8_advance(input logic [7:0] c);
    logic  ok;
    utf8_e nxt;
    if (u8_state == U_IDLE) begin
      if (c < 8'h80) u8_state = U_IDLE;
      else if (c >= 8'hC2 && c <= 8'hDF) u8_state = U_CONT1;
      else if (c == 8'hE0) u8_state = U_AFTER_E0;
      else if (c == 8'hED) u8_state = U_AFTER_ED;
      else if (c >= 8'hE1 && c <= 8'hEF) u8_state = U_CONT2;
      else if (c == 8'hF0) u8_state = U_AFTER_F0;
      else if (c >= 8'hF1 && c <= 8'hF3) u8_state = U_CONT3;
      else if (c == 8'hF4) u8_state = U_AFTER_F4;
      else begin
        rec_bad  = 1'b1;
        u8_state = U_IDLE;
      end
    end else begin
      case (u8_state)
        U_AFTER_E0: begin
          ok  = (c >= 8'hA0 && c <= 8'hBF);
          nxt = U_CONT1;
        end
        U_AFTER_ED: begin
          ok  = (c >= 8'h80 && c <= 8'h9F);
          nxt = U_CONT1;
        end
        U_AFTER_F0: begin
          ok  = (c >= 8'h90 && c <= 8'hBF);
          nxt = U_CONT2;
        end
        U_AFTER_F4: begin
          ok  = (c >= 8'h80 && c <= 8'h8F);
          nxt = U_CONT2;
        end
        U_CONT3: begin
          ok  = (c[7:6] == 2'b10);
          nxt = U_CONT2;
        end
        U_CONT2: begin
          ok  = (c[7:6] == 2'b10);
          nxt = U_CONT1;
        end
        default: begin
          ok  = (c[7:6] == 2'b10);
          nxt = U_IDLE;
        end
      endcase
      if (ok) u8_state = nxt;
      else begin
        rec_bad  = 1'b1;
        u8_state = U_IDLE;
      end
    end
  endfunction

  function automatic void record_byte(input logic [7:0] c);
    step_beats.push_back('{kind: KIND_BYTE, data: c, last: 1'b0});
    rec_open = 1'b1;
    utf8_advance(c);
  endfunction

  function automatic void close_record();
    logic bad;
    bad = rec_bad || (u8_state != U_IDLE);
    step_beats.push_back('{kind: (bin_mode || !bad) ? KIND_GOOD : KIND_DROP,
                           data: 8'h00, last: 1'b0});
    rec_open = 1'b0;
    rec_bad  = 1'b0;
    u8_state = U_IDLE;
  endfunction

  // Works out the beats that one accepted byte (or end of stream) releases.
  function automatic void predict_split(input logic [7:0] b, input logic eos);
    logic [7:0]  window[9];
    int unsigned len;
    int unsigned n;
    int unsigned keep;
    int unsigned cand;
    int unsigned i;
    bit          hit;
    step_beats.delete();
    len = eff_sep_len();
    if (held_cnt >= len) held_cnt = 4'(len - 1);
    if (eos) begin
      for (i = 0; i < held_cnt; i++) record_byte(sep_byte(i));
      held_cnt = '0;
      if (rec_open) close_record();
      rec_open = 1'b0;
      rec_bad  = 1'b0;
      u8_state = U_IDLE;
    end else begin
      n = held_cnt + 1;
      for (i = 0; i < held_cnt; i++) window[i] = sep_byte(i);
      window[held_cnt] = b;
      // Longest tail of the held bytes plus the new byte that opens a separator.
      keep = 0;
      for (cand = (n < len) ? n : len; cand > 0 && keep == 0; cand--) begin
        hit = 1'b1;
        for (i = 0; i < cand; i++) begin
          if (window[n - cand + i] != sep_byte(i)) hit = 1'b0;
        end
        if (hit) keep = cand;
      end
      for (i = 0; i < n - keep; i++) record_byte(window[i]);
      if (keep == len) begin
        if (incl_sep) begin
          for (i = 0; i < len; i++) record_byte(sep_byte(i));
        end
        close_record();
        held_cnt = '0;
      end else begin
        held_cnt = 4'(keep);
      end
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SEP_BYTES: sep_word = cfg_data_i;
          REG_SEP_LEN:   sep_len  = cfg_data_i[LenW-1:0];
          REG_INCL_SEP:  incl_sep = cfg_data_i[0];
          REG_BIN_MODE:  bin_mode = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) predict_split(data_byte_i, end_of_stream_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d out_byte %02h last %0b",
                 kind_o, out_byte_o, last_o);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind_o);
            mismatches++;
          end
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("delimited_record_splitter: mismatch");
    $finish;
  end

  // Receiver stalls follow a random mode that is redrawn when its random span runs out.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left  = $urandom_range(20, 80);
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_mask = 8'($urandom_range(1, 255));
    end
    mode_left--;
    case (ready_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      RDY_PATTERN: begin
        out_ready_i <= ready_mask[0];
        ready_mask = {ready_mask[0], ready_mask[7:1]};
      end
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] b, input logic eos);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (!steady_input) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(0, 5);
        if (gap > 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  endtask

  // Stops the sender and waits until every predicted beat has arrived.
  task automatic wait_results_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic set_config(input logic [63:0] sep, input logic [3:0] len,
                            input logic incl, input logic bin);
    wait_results_done();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SEP_BYTES;
    cfg_data_i  <= sep;
    @(negedge clk_i);
    cfg_index_i <= REG_SEP_LEN;
    cfg_data_i  <= {60'(rand64() >> 4), len};
    @(negedge clk_i);
    cfg_index_i <= REG_INCL_SEP;
    cfg_data_i  <= {63'(rand64() >> 1), incl};
    @(negedge clk_i);
    cfg_index_i <= REG_BIN_MODE;
    cfg_data_i  <= {63'(rand64() >> 1), bin};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_sep_prefix(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_item(sep_byte(i), 1'b0);
  endtask

  // One UTF-8 character with random content, now and then cut short.
  task automatic send_utf8_char();
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    int unsigned tail;
    int unsigned i;
    lo   = 8'h80;
    hi   = 8'hBF;
    tail = 0;
    case ($urandom_range(0, 7))
      0, 1: lead = 8'($urandom_range(0, 8'h7F));
      2: begin
        lead = 8'($urandom_range(8'hC2, 8'hDF));
        tail = 1;
      end
      3: begin
        lead = 8'hE0;
        lo   = 8'hA0;
        tail = 2;
      end
      4: begin
        lead = 8'hED;
        hi   = 8'h9F;
        tail = 2;
      end
      5: begin
        lead = 8'($urandom_range(8'hE1, 8'hEF));
        if (lead == 8'hED) lead = 8'hEE;
        tail = 2;
      end
      6: begin
        lead = 8'hF0;
        lo   = 8'h90;
        tail = 3;
      end
      default: begin
        tail = 3;
        if ($urandom_range(0, 1) != 0) begin
          lead = 8'hF4;
          hi   = 8'h8F;
        end else begin
          lead = 8'($urandom_range(8'hF1, 8'hF3));
        end
      end
    endcase
    send_item(lead, 1'b0);
    if (tail > 0 && $urandom_range(0, 9) == 0) tail = $urandom_range(0, tail - 1);
    for (i = 0; i < tail; i++) begin
      if (i == 0) send_item(8'($urandom_range(lo, hi)), 1'b0);
      else send_item(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
    end
  endtask

  // Records built from characters, partial and full separators, noise and
  // the odd end of stream.
  task automatic send_record_stream(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    target = items_sent + count;
    while (items_sent < target) begin
      len  = eff_sep_len();
      pick = $urandom_range(0, 99);
      if (pick < 45) send_utf8_char();
      else if (pick < 60 && len > 1) send_sep_prefix($urandom_range(1, len - 1));
      else if (pick < 75) send_sep_prefix(len);
      else if (pick < 94) send_item(8'($urandom_range(0, 255)), 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Line feed framing after reset: extreme bytes, an empty record, a sequence
  // left open at record end, a flushed tail and an empty end of stream.
  task automatic test_line_defaults();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h0A, 1'b0);
    send_item(8'h0A, 1'b0);
    send_item(8'hE2, 1'b0);
    send_item(8'h82, 1'b0);
    send_item(8'h0A, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);
  endtask

  // A zero length acts as one; an invalid record still ends as good.
  task automatic test_binary_mode();
    set_config(64'hFFFF_FFFF_FFFF_FF0A, 4'd0, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h0A, 1'b0);
  endtask

  // Separator "aab": a failed partial match keeps the longest prefix tail.
  task automatic test_overlapping_separator();
    set_config(64'h0000_0000_0062_6161, 4'd3, 1'b1, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // Two bytes held when the separator shrinks: the depth is cut back and the
  // held byte is reread from the new separator.
  task automatic test_config_while_holding();
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    set_config(64'h0000_0000_0000_6463, 4'd2, 1'b0, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_text();
    set_config(64'h0000_0000_0000_0A0D, 4'd2, 1'b1, 1'b0);
    send_record_stream(40);
    set_config(rand64(), 4'($urandom_range(3, 8)), 1'b0, 1'b0);
    send_record_stream(20);
    // The sender holds off until the splitter has delivered everything.
    wait_results_done();
    send_record_stream(20);
    steady_input = 1'b1;
    set_config(64'h6161_6161_6161_6161, 4'd15, 1'b1, 1'b0);
    send_record_stream(40);
    steady_input = 1'b0;
  endtask

  task automatic test_random_binary();
    set_config(64'h0, 4'd8, 1'b0, 1'b1);
    send_record_stream(40);
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'($urandom_range(1, 4)), 1'b1, 1'b1);
    send_record_stream(20);
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1, 1'b0);
    send_record_stream(20);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_SEP_BYTES;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_stream_i = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_line_defaults();
    test_binary_mode();
    test_overlapping_separator();
    test_config_while_holding();
    test_random_text();
    test_random_binary();

    wait_results_done();
    if (mismatches == 0) begin
      $display("delimited_record_splitter: match");
    end else begin
      $display("delimited_record_splitter: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_cell.sv
rtl/drs_utf8.sv
rtl/drs_emit.sv
rtl/delimited_record_splitter.sv
tb/delimited_record_splitter_test.sv
